[design/turing_machine_stepper_unit_defines.svh]
// Assertion macros shared by the stepper modules.
`ifndef TURING_MACHINE_STEPPER_UNIT_DEFINES_SVH
`define TURING_MACHINE_STEPPER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// Check a condition at every clock edge outside reset.
`define TMS_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a consequent in the same cycle as its antecedent.
`define TMS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check a consequent in the cycle after its antecedent.
`define TMS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define TMS_ASSERT(label, clk, rst_n, prop, msg)
`define TMS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define TMS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

[design/tms_pkg.sv]
package tms_pkg;

	localparam int OPCODE_W    = 2;
	localparam int SYM_W       = 8;
	localparam int STATE_W     = 4;
	localparam int MOVE_W      = 2;
	localparam int ADDR_W      = 10;
	localparam int STATUS_W    = 3;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 10;

	typedef enum logic [OPCODE_W-1:0] {
		OP_APPEND    = 2'd0,
		OP_LOAD_RULE = 2'd1,
		OP_STEP      = 2'd2,
		OP_READ      = 2'd3
	} opcode_t;

	localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
	localparam logic [STATUS_W-1:0] ST_HALTED   = 3'd1;
	localparam logic [STATUS_W-1:0] ST_NO_RULE  = 3'd2;
	localparam logic [STATUS_W-1:0] ST_OFF_TAPE = 3'd3;
	localparam logic [STATUS_W-1:0] ST_STOPPED  = 3'd4;

	localparam logic [MOVE_W-1:0] MV_LEFT  = 2'd0;
	localparam logic [MOVE_W-1:0] MV_RIGHT = 2'd1;

	localparam logic [CFG_INDEX_W-1:0] REG_START_STATE  = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_HALT_STATE   = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_BLANK_SYMBOL = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_HEAD_START   = 2'd3;

	localparam logic [STATE_W-1:0] RESET_START_STATE = 4'd0;
	localparam logic [STATE_W-1:0] RESET_HALT_STATE  = 4'd1;
	localparam logic [SYM_W-1:0]   RESET_BLANK       = 8'd46;
	localparam int                 RESET_HEAD_START  = 512;

	typedef struct packed {
		opcode_t                opcode;
		logic [SYM_W-1:0]       tape_symbol;
		logic [STATE_W-1:0]     rule_state;
		logic [SYM_W-1:0]       rule_write_symbol;
		logic [MOVE_W-1:0]      rule_move;
		logic [STATE_W-1:0]     rule_next_state;
		logic [ADDR_W-1:0]      cell_address;
	} req_item_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [STATE_W-1:0]  machine_state;
		logic [ADDR_W-1:0]   head_position;
		logic [SYM_W-1:0]    symbol_seen;
		logic [SYM_W-1:0]    symbol_written;
	} rsp_item_t;

	typedef struct packed {
		logic clear_en;
		logic accept;
		logic rule_rd;
		logic commit;
	} ctrl_cmd_t;

	typedef struct packed {
		logic clear_last;
		logic out_free;
	} ctrl_sts_t;

endpackage

[design/tms_if.sv]
interface tms_req_if;
	logic                              valid;
	logic                              ready;
	logic [tms_pkg::OPCODE_W-1:0]      opcode;
	logic [tms_pkg::SYM_W-1:0]         tape_symbol;
	logic [tms_pkg::STATE_W-1:0]       rule_state;
	logic [tms_pkg::SYM_W-1:0]         rule_write_symbol;
	logic [tms_pkg::MOVE_W-1:0]        rule_move;
	logic [tms_pkg::STATE_W-1:0]       rule_next_state;
	logic [tms_pkg::ADDR_W-1:0]        cell_address;

	modport source (
		output valid, opcode, tape_symbol, rule_state, rule_write_symbol, rule_move,
			rule_next_state, cell_address,
		input ready
	);
	modport sink (
		input valid, opcode, tape_symbol, rule_state, rule_write_symbol, rule_move,
			rule_next_state, cell_address,
		output ready
	);
endinterface

interface tms_rsp_if;
	logic                              valid;
	logic                              ready;
	logic [tms_pkg::STATUS_W-1:0]      status;
	logic [tms_pkg::STATE_W-1:0]       machine_state;
	logic [tms_pkg::ADDR_W-1:0]        head_position;
	logic [tms_pkg::SYM_W-1:0]         symbol_seen;
	logic [tms_pkg::SYM_W-1:0]         symbol_written;

	modport source (
		output valid, status, machine_state, head_position, symbol_seen, symbol_written,
		input ready
	);
	modport sink (
		input valid, status, machine_state, head_position, symbol_seen, symbol_written,
		output ready
	);
endinterface

[design/turing_machine_stepper_unit.sv]
// Channel   Dir  Handshake            Carries
// req       in   req.valid/req.ready  opcode, tape symbol, rule fields, cell address
// rsp       out  rsp.valid/rsp.ready  status, state, head, seen and written symbols
// cfg       in   cfg_we               register index and write data
//
// A step runs a tape read, a rule table read, then the tape write and state update;
// append, load rule and read skip the rule table read.
// After reset a clearing pass over max(min(TAPE_CELLS,1024), NUM_STATES*2**SYMBOL_BITS)
// entries (4096 at the defaults) runs before the first request is taken.
// One result register parts the sides: a new request is taken while a result waits,
// and the block stalls in its last cycle only when the next result finds it still full.
module turing_machine_stepper_unit #(
	parameter int TAPE_CELLS  = 1024,
	parameter int NUM_STATES  = 16,
	parameter int SYMBOL_BITS = 8
) (
	input  logic                               clk,
	input  logic                               arst_n,
	tms_req_if.sink                            req,
	tms_rsp_if.source                          rsp,
	input  logic                               cfg_we,
	input  logic [tms_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [tms_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

	tms_pkg::req_item_t  in_item;
	tms_pkg::ctrl_cmd_t  cmd;
	tms_pkg::ctrl_sts_t  sts;
	logic                in_ready;

	assign in_item.opcode            = tms_pkg::opcode_t'(req.opcode);
	assign in_item.tape_symbol       = req.tape_symbol;
	assign in_item.rule_state        = req.rule_state;
	assign in_item.rule_write_symbol = req.rule_write_symbol;
	assign in_item.rule_move         = req.rule_move;
	assign in_item.rule_next_state   = req.rule_next_state;
	assign in_item.cell_address      = req.cell_address;
	assign req.ready                 = in_ready;

	tms_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_opcode (in_item.opcode),
		.in_ready  (in_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	tms_dp #(
		.TAPE_CELLS  (TAPE_CELLS),
		.NUM_STATES  (NUM_STATES),
		.SYMBOL_BITS (SYMBOL_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_item   (in_item),
		.cmd       (cmd),
		.sts       (sts),
		.rsp       (rsp)
	);

endmodule

[design/tms_ctrl.sv]
`include "turing_machine_stepper_unit_defines.svh"

module tms_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  tms_pkg::opcode_t    in_opcode,
	output logic                in_ready,
	input  tms_pkg::ctrl_sts_t  sts,
	output tms_pkg::ctrl_cmd_t  cmd
);

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_LOOK,
		S_EXEC
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clear_en = 1'b1;
				if (sts.clear_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					// tape read goes out with the accept
					cmd.accept = 1'b1;
					state_d = (in_opcode == tms_pkg::OP_STEP) ? S_LOOK : S_EXEC;
				end
			end
			S_LOOK: begin
				cmd.rule_rd = 1'b1;
				state_d = S_EXEC;
			end
			S_EXEC: begin
				// hold until the output register can take the result
				if (sts.out_free) begin
					cmd.commit = 1'b1;
					state_d = S_IDLE;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	`TMS_ASSERT_NXT(a_step_looks_up, clk, arst_n, in_valid && in_ready && in_opcode == tms_pkg::OP_STEP, state_q == S_LOOK, "step request skipped rule lookup")
	`TMS_ASSERT_NXT(a_look_then_exec, clk, arst_n, state_q == S_LOOK, state_q == S_EXEC, "rule lookup not followed by execute")
	`TMS_ASSERT_NXT(a_exec_holds, clk, arst_n, state_q == S_EXEC && !sts.out_free, state_q == S_EXEC && !cmd.accept, "execute left while output full")

endmodule

[design/tms_dp.sv]
`include "turing_machine_stepper_unit_defines.svh"

module tms_dp #(
	parameter int TAPE_CELLS  = 1024,
	parameter int NUM_STATES  = 16,
	parameter int SYMBOL_BITS = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [tms_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [tms_pkg::CFG_DATA_W-1:0]      cfg_wdata,
	input  tms_pkg::req_item_t                  in_item,
	input  tms_pkg::ctrl_cmd_t                  cmd,
	output tms_pkg::ctrl_sts_t                  sts,
	tms_rsp_if.source                           rsp
);

	localparam int ADDR_W     = tms_pkg::ADDR_W;
	localparam int STATE_W    = tms_pkg::STATE_W;
	localparam int MOVE_W     = tms_pkg::MOVE_W;
	localparam int SYM_W      = tms_pkg::SYM_W;
	localparam int TAPE_SPAN  = (TAPE_CELLS < (1 << ADDR_W)) ? TAPE_CELLS : (1 << ADDR_W);
	localparam int TA_W       = $clog2(TAPE_SPAN);
	localparam int SIDX_W     = $clog2(NUM_STATES);
	localparam int RA_W       = SIDX_W + SYMBOL_BITS;
	localparam int RULE_DEPTH = NUM_STATES << SYMBOL_BITS;
	localparam int CLR_DEPTH  = (RULE_DEPTH > TAPE_SPAN) ? RULE_DEPTH : TAPE_SPAN;
	localparam int CW         = $clog2(CLR_DEPTH);
	localparam int RULE_W     = 1 + SYMBOL_BITS + MOVE_W + STATE_W;
	localparam int HEAD_RESET = tms_pkg::RESET_HEAD_START % TAPE_SPAN;

	// state index folded onto the rule table rows
	function automatic logic [SIDX_W-1:0] state_index(input logic [STATE_W-1:0] st);
		logic [11:0] v;
		v = 12'(st);
		for (int k = 2; k >= 0; k--) begin
			if (v >= 12'(NUM_STATES << k)) begin
				v = v - 12'(NUM_STATES << k);
			end
		end
		return v[SIDX_W-1:0];
	endfunction

	// head start folded onto the tape span
	function automatic logic [ADDR_W-1:0] head_wrap(input logic [ADDR_W-1:0] a);
		logic [16:0] w;
		w = 17'(a);
		for (int k = 5; k >= 0; k--) begin
			if (w >= 17'(TAPE_SPAN << k)) begin
				w = w - 17'(TAPE_SPAN << k);
			end
		end
		return w[ADDR_W-1:0];
	endfunction

	tms_pkg::req_item_t item_q;
	tms_pkg::rsp_item_t out_q;
	tms_pkg::rsp_item_t res;

	logic [SYMBOL_BITS:0]   tape_mem [TAPE_SPAN];
	logic [SYMBOL_BITS:0]   tape_rd_q;
	logic [RULE_W-1:0]      rule_mem [RULE_DEPTH];
	logic [RULE_W-1:0]      rule_rd_q;
	logic [CW-1:0]          clr_q;

	logic [STATE_W-1:0]     halt_q;
	logic [SYM_W-1:0]       blank_q;
	logic [ADDR_W-1:0]      head_q;
	logic [ADDR_W-1:0]      load_q;
	logic                   load_full_q;
	logic [STATE_W-1:0]     cur_state_q;
	logic                   stopped_q;
	logic                   out_valid_q;

	logic [ADDR_W-1:0]      tape_rd_addr;
	logic [SYMBOL_BITS-1:0] blank_sym;
	logic [SYMBOL_BITS-1:0] seen_sym;
	logic [SYMBOL_BITS-1:0] read_sym;
	logic                   read_off;
	logic [RA_W-1:0]        rule_rd_idx;
	logic [RA_W-1:0]        rule_wr_idx;
	logic                   r_valid;
	logic [SYMBOL_BITS-1:0] r_wsym;
	logic [MOVE_W-1:0]      r_move;
	logic [STATE_W-1:0]     r_next;
	logic                   clr_tape;
	logic                   clr_rule;

	logic [ADDR_W-1:0]      nxt_head;
	logic [ADDR_W-1:0]      nxt_load;
	logic                   nxt_full;
	logic [STATE_W-1:0]     nxt_state;
	logic                   nxt_stop;
	logic                   move_off;
	logic                   tape_we;
	logic [ADDR_W-1:0]      tape_wa;
	logic [SYMBOL_BITS:0]   tape_wd;
	logic                   rule_we;

	assign tape_rd_addr = (in_item.opcode == tms_pkg::OP_READ) ? in_item.cell_address : head_q;
	assign blank_sym    = blank_q[SYMBOL_BITS-1:0];
	assign seen_sym     = tape_rd_q[SYMBOL_BITS] ? tape_rd_q[SYMBOL_BITS-1:0] : blank_sym;
	assign read_off     = int'(item_q.cell_address) >= TAPE_SPAN;
	assign read_sym     = read_off ? blank_sym : seen_sym;
	assign rule_rd_idx  = {state_index(cur_state_q), seen_sym};
	assign rule_wr_idx  = {state_index(item_q.rule_state), item_q.tape_symbol[SYMBOL_BITS-1:0]};
	assign r_valid      = rule_rd_q[RULE_W-1];
	assign r_wsym       = rule_rd_q[RULE_W-2 -: SYMBOL_BITS];
	assign r_move       = rule_rd_q[MOVE_W+STATE_W-1 -: MOVE_W];
	assign r_next       = rule_rd_q[STATE_W-1:0];
	assign clr_tape     = int'(clr_q) < TAPE_SPAN;
	assign clr_rule     = int'(clr_q) < RULE_DEPTH;

	assign sts.clear_last = int'(clr_q) == (CLR_DEPTH - 1);
	assign sts.out_free   = !out_valid_q || rsp.ready;

	always_comb begin
		nxt_head  = head_q;
		nxt_load  = load_q;
		nxt_full  = load_full_q;
		nxt_state = cur_state_q;
		nxt_stop  = stopped_q;
		move_off  = 1'b0;
		tape_we   = 1'b0;
		tape_wa   = head_q;
		tape_wd   = {1'b1, item_q.tape_symbol[SYMBOL_BITS-1:0]};
		rule_we   = 1'b0;
		res       = '0;
		res.status = tms_pkg::ST_OK;
		unique case (item_q.opcode)
			tms_pkg::OP_APPEND: begin
				if (load_full_q) begin
					res.status = tms_pkg::ST_OFF_TAPE;
				end else begin
					tape_we = 1'b1;
					tape_wa = load_q;
					if (int'(load_q) + 1 >= TAPE_SPAN) begin
						nxt_full = 1'b1;
					end else begin
						nxt_load = load_q + ADDR_W'(1);
					end
				end
			end
			tms_pkg::OP_LOAD_RULE: begin
				rule_we = 1'b1;
			end
			tms_pkg::OP_STEP: begin
				if (stopped_q) begin
					res.status = tms_pkg::ST_STOPPED;
				end else if (!r_valid) begin
					res.status      = tms_pkg::ST_NO_RULE;
					res.symbol_seen = SYM_W'(seen_sym);
					nxt_stop        = 1'b1;
				end else begin
					res.symbol_seen = SYM_W'(seen_sym);
					tape_we = 1'b1;
					tape_wd = {1'b1, r_wsym};
					case (r_move)
						tms_pkg::MV_RIGHT: begin
							if (int'(head_q) + 1 >= TAPE_SPAN) begin
								move_off = 1'b1;
							end else begin
								nxt_head = head_q + ADDR_W'(1);
							end
						end
						tms_pkg::MV_LEFT: begin
							if (head_q == '0) begin
								move_off = 1'b1;
							end else begin
								nxt_head = head_q - ADDR_W'(1);
							end
						end
						default: begin
							// stay
						end
					endcase
					if (move_off) begin
						res.status = tms_pkg::ST_OFF_TAPE;
						nxt_stop   = 1'b1;
					end else begin
						res.symbol_written = SYM_W'(r_wsym);
						nxt_state = r_next;
						if (r_next == halt_q) begin
							res.status = tms_pkg::ST_HALTED;
							nxt_stop   = 1'b1;
						end
					end
				end
			end
			tms_pkg::OP_READ: begin
				res.symbol_seen = SYM_W'(read_sym);
				if (read_off) begin
					res.status = tms_pkg::ST_OFF_TAPE;
				end
			end
		endcase
		res.machine_state = nxt_state;
		res.head_position = nxt_head;
	end

	// tape: clearing pass marks every cell unwritten
	always_ff @(posedge clk) begin
		if (cmd.clear_en && clr_tape) begin
			tape_mem[clr_q[TA_W-1:0]] <= '0;
		end else if (cmd.commit && tape_we) begin
			tape_mem[tape_wa[TA_W-1:0]] <= tape_wd;
		end
		if (cmd.accept) begin
			tape_rd_q <= tape_mem[tape_rd_addr[TA_W-1:0]];
		end
	end

	// rule table: clearing pass drops every valid bit
	always_ff @(posedge clk) begin
		if (cmd.clear_en && clr_rule) begin
			rule_mem[clr_q[RA_W-1:0]] <= '0;
		end else if (cmd.commit && rule_we) begin
			rule_mem[rule_wr_idx] <= {1'b1, item_q.rule_write_symbol[SYMBOL_BITS-1:0],
				item_q.rule_move, item_q.rule_next_state};
		end
		if (cmd.rule_rd) begin
			rule_rd_q <= rule_mem[rule_rd_idx];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			item_q <= in_item;
		end
		if (cmd.commit) begin
			out_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			halt_q      <= tms_pkg::RESET_HALT_STATE;
			blank_q     <= tms_pkg::RESET_BLANK;
			head_q      <= ADDR_W'(HEAD_RESET);
			load_q      <= ADDR_W'(HEAD_RESET);
			load_full_q <= 1'b0;
			cur_state_q <= tms_pkg::RESET_START_STATE;
			stopped_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clear_en) begin
				clr_q <= clr_q + CW'(1);
			end
			if (cmd.commit) begin
				head_q      <= nxt_head;
				load_q      <= nxt_load;
				load_full_q <= nxt_full;
				cur_state_q <= nxt_state;
				stopped_q   <= nxt_stop;
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				unique case (cfg_index)
					tms_pkg::REG_START_STATE: begin
						// a new start also starts a new run
						cur_state_q <= cfg_wdata[STATE_W-1:0];
						stopped_q   <= 1'b0;
					end
					tms_pkg::REG_HALT_STATE: begin
						halt_q <= cfg_wdata[STATE_W-1:0];
					end
					tms_pkg::REG_BLANK_SYMBOL: begin
						blank_q <= cfg_wdata[SYM_W-1:0];
					end
					tms_pkg::REG_HEAD_START: begin
						head_q      <= head_wrap(cfg_wdata[ADDR_W-1:0]);
						load_q      <= head_wrap(cfg_wdata[ADDR_W-1:0]);
						load_full_q <= 1'b0;
					end
					default: begin
					end
				endcase
			end
		end
	end

	assign rsp.valid          = out_valid_q;
	assign rsp.status         = out_q.status;
	assign rsp.machine_state  = out_q.machine_state;
	assign rsp.head_position  = out_q.head_position;
	assign rsp.symbol_seen    = out_q.symbol_seen;
	assign rsp.symbol_written = out_q.symbol_written;

	`TMS_ASSERT(a_head_in_span, clk, arst_n, int'(head_q) < TAPE_SPAN, "head outside tape span")
	`TMS_ASSERT_NXT(a_commit_fills_out, clk, arst_n, cmd.commit, out_valid_q, "result lost on commit")
	`TMS_ASSERT_NXT(a_stopped_step_inert, clk, arst_n, cmd.commit && item_q.opcode == tms_pkg::OP_STEP && stopped_q, stopped_q && $stable(head_q) && $stable(cur_state_q), "step while stopped changed the machine")

endmodule

[tb/turing_machine_stepper_unit_test.sv]
`timescale 1ns / 1ps

module turing_machine_stepper_unit_test;

	localparam logic [tms_pkg::MOVE_W-1:0] MV_STAY     = 2'd2;
	localparam logic [tms_pkg::MOVE_W-1:0] MV_STAY_ALT = 2'd3;
	localparam logic [tms_pkg::ADDR_W-1:0] TAPE_LAST   = 10'd1023;
	localparam int                         RANDOM_ITEMS = 1600;

	typedef struct packed {
		logic                            is_reg;
		logic [tms_pkg::CFG_INDEX_W-1:0] reg_idx;
		logic [tms_pkg::CFG_DATA_W-1:0]  reg_val;
		tms_pkg::req_item_t              req;
		logic                            has_exp;
		tms_pkg::rsp_item_t              exp;
	} bench_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [tms_pkg::CFG_INDEX_W-1:0] cfg_index;
	logic [tms_pkg::CFG_DATA_W-1:0]  cfg_wdata;

	tms_req_if req_ch();
	tms_rsp_if rsp_ch();

	turing_machine_stepper_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Machine copy kept by the bench
	logic [tms_pkg::SYM_W-1:0]   tape_mem [1024];
	bit                          tape_set [1024];
	bit                          rule_ok [4096];
	logic [tms_pkg::SYM_W-1:0]   rule_wsym [4096];
	logic [tms_pkg::MOVE_W-1:0]  rule_mv [4096];
	logic [tms_pkg::STATE_W-1:0] rule_nxt [4096];
	logic [tms_pkg::ADDR_W-1:0]  m_head, m_load;
	logic [tms_pkg::STATE_W-1:0] m_state;
	bit                          m_load_full, m_stopped;
	logic [tms_pkg::STATE_W-1:0] c_start, c_halt;
	logic [tms_pkg::SYM_W-1:0]   c_blank;

	tms_pkg::rsp_item_t awaited_results [$];
	bench_row_t dir_rows [$];

	int tx_idle_pct = 0;
	int rx_stall_pct = 0;
	int mismatches = 0;
	int results_seen = 0;
	int items_sent = 0;
	int runs_done = 0;
	int n_steps = 0, n_halts = 0, n_faults = 0, n_refused = 0;

	function automatic void add_row(bench_row_t row);
		dir_rows.insert(dir_rows.size(), row);
	endfunction

	function automatic logic [tms_pkg::SYM_W-1:0] tape_symbol_at(
		logic [tms_pkg::ADDR_W-1:0] a);
		return tape_set[a] ? tape_mem[a] : c_blank;
	endfunction

	function automatic void apply_reg(logic [tms_pkg::CFG_INDEX_W-1:0] idx,
		logic [tms_pkg::CFG_DATA_W-1:0] val);
		case (idx)
			tms_pkg::REG_START_STATE: begin
				c_start = val[tms_pkg::STATE_W-1:0];
				m_state = c_start;
				m_stopped = 1'b0;
			end
			tms_pkg::REG_HALT_STATE: c_halt = val[tms_pkg::STATE_W-1:0];
			tms_pkg::REG_BLANK_SYMBOL: c_blank = val[tms_pkg::SYM_W-1:0];
			tms_pkg::REG_HEAD_START: begin
				m_head = val[tms_pkg::ADDR_W-1:0];
				m_load = val[tms_pkg::ADDR_W-1:0];
				m_load_full = 1'b0;
			end
			default: ;
		endcase
	endfunction

	function automatic tms_pkg::rsp_item_t advance_machine(tms_pkg::req_item_t r);
		tms_pkg::rsp_item_t o;
		logic [tms_pkg::STATE_W+tms_pkg::SYM_W-1:0] ix;
		logic [tms_pkg::SYM_W-1:0] seen;
		bit off;
		o = '0;
		case (r.opcode)
			tms_pkg::OP_APPEND: begin
				if (m_load_full) begin
					o.status = tms_pkg::ST_OFF_TAPE;
				end else begin
					tape_mem[m_load] = r.tape_symbol;
					tape_set[m_load] = 1'b1;
					if (m_load == TAPE_LAST)
						m_load_full = 1'b1;
					else
						m_load = m_load + tms_pkg::ADDR_W'(1);
				end
			end
			tms_pkg::OP_LOAD_RULE: begin
				ix = {r.rule_state, r.tape_symbol};
				rule_ok[ix] = 1'b1;
				rule_wsym[ix] = r.rule_write_symbol;
				rule_mv[ix] = r.rule_move;
				rule_nxt[ix] = r.rule_next_state;
			end
			tms_pkg::OP_STEP: begin
				if (m_stopped) begin
					o.status = tms_pkg::ST_STOPPED;
				end else begin
					seen = tape_symbol_at(m_head);
					o.symbol_seen = seen;
					ix = {m_state, seen};
					if (!rule_ok[ix]) begin
						o.status = tms_pkg::ST_NO_RULE;
						m_stopped = 1'b1;
					end else begin
						off = 1'b0;
						tape_mem[m_head] = rule_wsym[ix];
						tape_set[m_head] = 1'b1;
						if (rule_mv[ix] == tms_pkg::MV_RIGHT) begin
							if (m_head == TAPE_LAST)
								off = 1'b1;
							else
								m_head = m_head + tms_pkg::ADDR_W'(1);
						end else if (rule_mv[ix] == tms_pkg::MV_LEFT) begin
							if (m_head == '0)
								off = 1'b1;
							else
								m_head = m_head - tms_pkg::ADDR_W'(1);
						end
						if (off) begin
							o.status = tms_pkg::ST_OFF_TAPE;
							m_stopped = 1'b1;
						end else begin
							o.symbol_written = rule_wsym[ix];
							m_state = rule_nxt[ix];
							if (m_state == c_halt) begin
								o.status = tms_pkg::ST_HALTED;
								m_stopped = 1'b1;
							end
						end
					end
				end
			end
			default: o.symbol_seen = tape_symbol_at(r.cell_address);
		endcase
		o.machine_state = m_state;
		o.head_position = m_head;
		return o;
	endfunction

	function automatic bench_row_t reg_row(logic [tms_pkg::CFG_INDEX_W-1:0] idx,
		logic [tms_pkg::CFG_DATA_W-1:0] val);
		bench_row_t row;
		row = '0;
		row.is_reg = 1'b1;
		row.reg_idx = idx;
		row.reg_val = val;
		return row;
	endfunction

	function automatic bench_row_t req_row(tms_pkg::opcode_t op,
		logic [tms_pkg::SYM_W-1:0] sym, logic [tms_pkg::STATE_W-1:0] st,
		logic [tms_pkg::SYM_W-1:0] ws, logic [tms_pkg::MOVE_W-1:0] mv,
		logic [tms_pkg::STATE_W-1:0] nx, logic [tms_pkg::ADDR_W-1:0] ad);
		bench_row_t row;
		row = '0;
		row.req = '{op, sym, st, ws, mv, nx, ad};
		return row;
	endfunction

	function automatic bench_row_t with_exp(bench_row_t row,
		logic [tms_pkg::STATUS_W-1:0] st, logic [tms_pkg::STATE_W-1:0] ms,
		logic [tms_pkg::ADDR_W-1:0] hp, logic [tms_pkg::SYM_W-1:0] ss,
		logic [tms_pkg::SYM_W-1:0] sw);
		row.has_exp = 1'b1;
		row.exp = '{st, ms, hp, ss, sw};
		return row;
	endfunction

	function automatic tms_pkg::req_item_t noise_request();
		tms_pkg::req_item_t r;
		r.opcode = tms_pkg::opcode_t'($urandom_range(3));
		r.tape_symbol = tms_pkg::SYM_W'($urandom_range(255));
		r.rule_state = tms_pkg::STATE_W'($urandom_range(15));
		r.rule_write_symbol = tms_pkg::SYM_W'($urandom_range(255));
		r.rule_move = tms_pkg::MOVE_W'($urandom_range(3));
		r.rule_next_state = tms_pkg::STATE_W'($urandom_range(15));
		r.cell_address = tms_pkg::ADDR_W'($urandom_range(1023));
		return r;
	endfunction

	task automatic send_request(tms_pkg::req_item_t it, bit use_exp,
		tms_pkg::rsp_item_t exp);
		tms_pkg::rsp_item_t want;
		while ($urandom_range(99) < tx_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.opcode <= it.opcode;
		req_ch.tape_symbol <= it.tape_symbol;
		req_ch.rule_state <= it.rule_state;
		req_ch.rule_write_symbol <= it.rule_write_symbol;
		req_ch.rule_move <= it.rule_move;
		req_ch.rule_next_state <= it.rule_next_state;
		req_ch.cell_address <= it.cell_address;
		do
			@(posedge clk);
		while (!req_ch.ready);
		want = advance_machine(it);
		if (use_exp)
			want = exp;
		awaited_results.insert(awaited_results.size(), want);
		items_sent++;
		if (it.opcode == tms_pkg::OP_STEP) begin
			n_steps++;
			if (want.status == tms_pkg::ST_HALTED)
				n_halts++;
			else if (want.status == tms_pkg::ST_NO_RULE
				|| want.status == tms_pkg::ST_OFF_TAPE)
				n_faults++;
			else if (want.status == tms_pkg::ST_STOPPED)
				n_refused++;
		end
	endtask

	task automatic wait_drained();
		req_ch.valid <= 1'b0;
		while (awaited_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(logic [tms_pkg::CFG_INDEX_W-1:0] idx,
		logic [tms_pkg::CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		apply_reg(idx, val);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// One run: set registers, then either a rule program with steps or plain noise
	task automatic run_program(int run);
		logic [tms_pkg::CFG_DATA_W-1:0] vals [4];
		logic [tms_pkg::SYM_W-1:0] alpha [3];
		logic [tms_pkg::STATE_W-1:0] states [4];
		int n_states, first, n_steps_run, sel;
		bit halt_reachable;
		tms_pkg::req_item_t r;
		tms_pkg::rsp_item_t dummy;
		dummy = '0;
		wait_drained();
		case (run % 4)
			0: begin tx_idle_pct = 0; rx_stall_pct = 0; end
			1: begin tx_idle_pct = 70; rx_stall_pct = 0; end
			2: begin tx_idle_pct = 0; rx_stall_pct = 70; end
			default: begin tx_idle_pct = 28; rx_stall_pct = 28; end
		endcase
		if (run == 0) begin
			vals = '{10'd15, 10'd15, 10'd255, 10'd1023};
		end else if (run == 1) begin
			vals = '{10'd0, 10'd0, 10'd0, 10'd0};
		end else begin
			vals[tms_pkg::REG_START_STATE] = tms_pkg::CFG_DATA_W'($urandom_range(15));
			vals[tms_pkg::REG_HALT_STATE] = tms_pkg::CFG_DATA_W'($urandom_range(15));
			vals[tms_pkg::REG_BLANK_SYMBOL] = tms_pkg::CFG_DATA_W'($urandom_range(255));
			case ($urandom_range(9))
				0: vals[tms_pkg::REG_HEAD_START] = tms_pkg::CFG_DATA_W'($urandom_range(6));
				1: vals[tms_pkg::REG_HEAD_START] =
					tms_pkg::CFG_DATA_W'($urandom_range(1023, 1017));
				default: vals[tms_pkg::REG_HEAD_START] =
					tms_pkg::CFG_DATA_W'($urandom_range(700, 300));
			endcase
		end
		first = $urandom_range(3);
		for (int i = 0; i < 4; i++)
			write_reg(tms_pkg::CFG_INDEX_W'((first + i) % 4), vals[(first + i) % 4]);

		if (run > 1 && $urandom_range(3) == 0) begin
			repeat ($urandom_range(60, 30))
				send_request(noise_request(), 1'b0, dummy);
			return;
		end

		alpha[0] = c_blank;
		alpha[1] = tms_pkg::SYM_W'($urandom_range(255));
		alpha[2] = tms_pkg::SYM_W'($urandom_range(255));
		n_states = $urandom_range(4, 2);
		states[0] = c_start;
		for (int i = 1; i < 4; i++)
			states[i] = tms_pkg::STATE_W'($urandom_range(15));
		halt_reachable = ($urandom_range(2) == 0);

		r = '0;
		repeat ($urandom_range(8)) begin
			r.opcode = tms_pkg::OP_APPEND;
			r.tape_symbol = alpha[$urandom_range(2)];
			send_request(r, 1'b0, dummy);
		end
		for (int s = 0; s < n_states; s++) begin
			for (int a = 0; a < 3; a++) begin
				// leave a hole now and then so a run can miss a rule
				if ($urandom_range(14) != 0) begin
					r = noise_request();
					r.opcode = tms_pkg::OP_LOAD_RULE;
					r.rule_state = states[s];
					r.tape_symbol = alpha[a];
					if ($urandom_range(19) != 0)
						r.rule_write_symbol = alpha[$urandom_range(2)];
					sel = $urandom_range(9);
					if (sel < 4)
						r.rule_move = tms_pkg::MV_LEFT;
					else if (sel < 8)
						r.rule_move = tms_pkg::MV_RIGHT;
					else if (sel == 8)
						r.rule_move = MV_STAY;
					else
						r.rule_move = MV_STAY_ALT;
					if (halt_reachable && $urandom_range(7) == 0)
						r.rule_next_state = c_halt;
					else
						r.rule_next_state = states[$urandom_range(n_states - 1)];
					send_request(r, 1'b0, dummy);
				end
			end
		end
		n_steps_run = $urandom_range(60, 30);
		for (int k = 0; k < n_steps_run; k++) begin
			// hold off until the block is empty
			if (run == 5 && k == n_steps_run / 2)
				wait_drained();
			sel = $urandom_range(19);
			if (sel < 2) begin
				r = noise_request();
				r.opcode = tms_pkg::OP_READ;
				r.cell_address = tms_pkg::ADDR_W'(int'(m_head) + $urandom_range(8) - 4);
			end else if (sel == 2) begin
				r = noise_request();
			end else begin
				r = noise_request();
				r.opcode = tms_pkg::OP_STEP;
			end
			send_request(r, 1'b0, dummy);
		end
	endtask

	task automatic report_field(string name, int unsigned want, int unsigned got);
		$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		mismatches++;
	endtask

	// Result side: check each accepted result, then pick the next ready value
	initial begin
		tms_pkg::rsp_item_t got, want;
		rsp_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
				got = {rsp_ch.status, rsp_ch.machine_state, rsp_ch.head_position,
					rsp_ch.symbol_seen, rsp_ch.symbol_written};
				results_seen++;
				if (awaited_results.size() == 0) begin
					$display("%0t: result with none pending, expected nothing, actual %h",
						$time, got);
					mismatches++;
				end else begin
					want = awaited_results.pop_front();
					if (want.status !== got.status)
						report_field("status", 32'(want.status), 32'(got.status));
					if (want.machine_state !== got.machine_state)
						report_field("machine_state", 32'(want.machine_state),
							32'(got.machine_state));
					if (want.head_position !== got.head_position)
						report_field("head_position", 32'(want.head_position),
							32'(got.head_position));
					if (want.symbol_seen !== got.symbol_seen)
						report_field("symbol_seen", 32'(want.symbol_seen),
							32'(got.symbol_seen));
					if (want.symbol_written !== got.symbol_written)
						report_field("symbol_written", 32'(want.symbol_written),
							32'(got.symbol_written));
				end
			end
			if (arst_n)
				rsp_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
		end
	end

	initial begin
		#(5_000_000);
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		int run;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		req_ch.valid = 1'b0;
		req_ch.opcode = '0;
		req_ch.tape_symbol = '0;
		req_ch.rule_state = '0;
		req_ch.rule_write_symbol = '0;
		req_ch.rule_move = '0;
		req_ch.rule_next_state = '0;
		req_ch.cell_address = '0;
		for (int i = 0; i < 1024; i++) begin
			tape_set[i] = 1'b0;
			tape_mem[i] = '0;
		end
		for (int i = 0; i < 4096; i++)
			rule_ok[i] = 1'b0;
		c_start = tms_pkg::RESET_START_STATE;
		c_halt = tms_pkg::RESET_HALT_STATE;
		c_blank = tms_pkg::RESET_BLANK;
		m_head = tms_pkg::ADDR_W'(tms_pkg::RESET_HEAD_START);
		m_load = tms_pkg::ADDR_W'(tms_pkg::RESET_HEAD_START);
		m_state = tms_pkg::RESET_START_STATE;
		m_load_full = 1'b0;
		m_stopped = 1'b0;

		// blank tape reads, missing rule, then refusal while stopped
		add_row(with_exp(req_row(tms_pkg::OP_READ, 8'h00, 4'd0, 8'h00, tms_pkg::MV_LEFT,
			4'd0, 10'd512), tms_pkg::ST_OK, 4'd0, 10'd512, 8'd46, 8'h00));
		add_row(with_exp(req_row(tms_pkg::OP_READ, 8'hff, 4'd15, 8'hff, MV_STAY_ALT,
			4'd15, 10'd0), tms_pkg::ST_OK, 4'd0, 10'd512, 8'd46, 8'h00));
		add_row(with_exp(req_row(tms_pkg::OP_READ, 8'h00, 4'd0, 8'h00, tms_pkg::MV_LEFT,
			4'd0, 10'd1023), tms_pkg::ST_OK, 4'd0, 10'd512, 8'd46, 8'h00));
		add_row(with_exp(req_row(tms_pkg::OP_STEP, 8'h00, 4'd0, 8'h00, tms_pkg::MV_LEFT,
			4'd0, 10'd0), tms_pkg::ST_NO_RULE, 4'd0, 10'd512, 8'd46, 8'h00));
		add_row(with_exp(req_row(tms_pkg::OP_STEP, 8'hff, 4'd15, 8'hff, MV_STAY_ALT,
			4'd15, 10'd1023), tms_pkg::ST_STOPPED, 4'd0, 10'd512, 8'h00, 8'h00));
		// loading works while stopped
		add_row(with_exp(req_row(tms_pkg::OP_APPEND, 8'hff, 4'd0, 8'h00, tms_pkg::MV_LEFT,
			4'd0, 10'd0), tms_pkg::ST_OK, 4'd0, 10'd512, 8'h00, 8'h00));
		add_row(with_exp(req_row(tms_pkg::OP_APPEND, 8'h00, 4'd0, 8'h00, tms_pkg::MV_LEFT,
			4'd0, 10'd0), tms_pkg::ST_OK, 4'd0, 10'd512, 8'h00, 8'h00));
		add_row(with_exp(req_row(tms_pkg::OP_LOAD_RULE, 8'hff, 4'd0, 8'h00,
			tms_pkg::MV_RIGHT, 4'd15, 10'd0), tms_pkg::ST_OK, 4'd0, 10'd512, 8'h00, 8'h00));
		add_row(with_exp(req_row(tms_pkg::OP_LOAD_RULE, 8'h00, 4'd15, 8'haa, MV_STAY_ALT,
			4'd1, 10'd0), tms_pkg::ST_OK, 4'd0, 10'd512, 8'h00, 8'h00));
		add_row(with_exp(req_row(tms_pkg::OP_READ, 8'h00, 4'd0, 8'h00, tms_pkg::MV_LEFT,
			4'd0, 10'd512), tms_pkg::ST_OK, 4'd0, 10'd512, 8'hff, 8'h00));
		add_row(req_row(tms_pkg::OP_READ, 8'h00, 4'd0, 8'h00, tms_pkg::MV_LEFT, 4'd0,
			10'd513));
		// restart, step right, then halt with the odd move code
		add_row(reg_row(tms_pkg::REG_START_STATE, 10'd0));
		add_row(with_exp(req_row(tms_pkg::OP_STEP, 8'h00, 4'd0, 8'h00, tms_pkg::MV_LEFT,
			4'd0, 10'd0), tms_pkg::ST_OK, 4'd15, 10'd513, 8'hff, 8'h00));
		add_row(with_exp(req_row(tms_pkg::OP_STEP, 8'h00, 4'd0, 8'h00, tms_pkg::MV_LEFT,
			4'd0, 10'd0), tms_pkg::ST_HALTED, 4'd1, 10'd513, 8'h00, 8'haa));
		add_row(with_exp(req_row(tms_pkg::OP_STEP, 8'h00, 4'd0, 8'h00, tms_pkg::MV_LEFT,
			4'd0, 10'd0), tms_pkg::ST_STOPPED, 4'd1, 10'd513, 8'h00, 8'h00));
		// last cell: append past the end, move off the right end
		add_row(reg_row(tms_pkg::REG_HEAD_START, 10'd1023));
		add_row(with_exp(req_row(tms_pkg::OP_APPEND, 8'h00, 4'd0, 8'h00, tms_pkg::MV_LEFT,
			4'd0, 10'd0), tms_pkg::ST_OK, 4'd1, 10'd1023, 8'h00, 8'h00));
		add_row(with_exp(req_row(tms_pkg::OP_APPEND, 8'h11, 4'd0, 8'h00, tms_pkg::MV_LEFT,
			4'd0, 10'd0), tms_pkg::ST_OFF_TAPE, 4'd1, 10'd1023, 8'h00, 8'h00));
		add_row(req_row(tms_pkg::OP_LOAD_RULE, 8'h00, 4'd15, 8'h55, tms_pkg::MV_RIGHT,
			4'd3, 10'd0));
		add_row(reg_row(tms_pkg::REG_START_STATE, 10'd15));
		add_row(with_exp(req_row(tms_pkg::OP_STEP, 8'h00, 4'd0, 8'h00, tms_pkg::MV_LEFT,
			4'd0, 10'd0), tms_pkg::ST_OFF_TAPE, 4'd15, 10'd1023, 8'h00, 8'h00));
		add_row(with_exp(req_row(tms_pkg::OP_READ, 8'h00, 4'd0, 8'h00, tms_pkg::MV_LEFT,
			4'd0, 10'd1023), tms_pkg::ST_OK, 4'd15, 10'd1023, 8'h55, 8'h00));
		// first cell: move off the left end
		add_row(reg_row(tms_pkg::REG_HEAD_START, 10'd0));
		add_row(reg_row(tms_pkg::REG_START_STATE, 10'd0));
		add_row(req_row(tms_pkg::OP_LOAD_RULE, 8'd46, 4'd0, 8'h01, tms_pkg::MV_LEFT,
			4'd2, 10'd0));
		add_row(with_exp(req_row(tms_pkg::OP_STEP, 8'h00, 4'd0, 8'h00, tms_pkg::MV_LEFT,
			4'd0, 10'd0), tms_pkg::ST_OFF_TAPE, 4'd0, 10'd0, 8'd46, 8'h00));
		add_row(reg_row(tms_pkg::REG_BLANK_SYMBOL, 10'd255));
		add_row(with_exp(req_row(tms_pkg::OP_READ, 8'h00, 4'd0, 8'h00, tms_pkg::MV_LEFT,
			4'd0, 10'd5), tms_pkg::ST_OK, 4'd0, 10'd0, 8'hff, 8'h00));
		// start equals halt: only a step can halt
		add_row(reg_row(tms_pkg::REG_BLANK_SYMBOL, 10'd0));
		add_row(reg_row(tms_pkg::REG_HALT_STATE, 10'd0));
		add_row(reg_row(tms_pkg::REG_START_STATE, 10'd0));
		add_row(req_row(tms_pkg::OP_LOAD_RULE, 8'h01, 4'd0, 8'h02, MV_STAY, 4'd0, 10'd0));
		add_row(with_exp(req_row(tms_pkg::OP_STEP, 8'h00, 4'd0, 8'h00, tms_pkg::MV_LEFT,
			4'd0, 10'd0), tms_pkg::ST_HALTED, 4'd0, 10'd0, 8'h01, 8'h02));
		add_row(with_exp(req_row(tms_pkg::OP_READ, 8'h00, 4'd0, 8'h00, tms_pkg::MV_LEFT,
			4'd0, 10'd6), tms_pkg::ST_OK, 4'd0, 10'd0, 8'h00, 8'h00));

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i]) begin
			if (dir_rows[i].is_reg) begin
				wait_drained();
				write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_val);
			end else begin
				send_request(dir_rows[i].req, dir_rows[i].has_exp, dir_rows[i].exp);
			end
		end

		run = 0;
		while (items_sent < dir_rows.size() + RANDOM_ITEMS) begin
			run_program(run);
			run++;
		end
		runs_done = run;

		wait_drained();
		repeat (10) @(posedge clk);
		$display("Sent %0d requests over %0d register settings; %0d steps: %0d halted, %0d faulted, %0d refused.",
			items_sent, runs_done, n_steps, n_halts, n_faults, n_refused);
		$display("Checked %0d results with sender gaps and result stalls mixed per run.",
			results_seen);
		if (mismatches == 0 && awaited_results.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
